>>> design/tdc_pkg.sv
package tdc_pkg;

    // Depth of the temperature averaging window.
    localparam int WINDOW = 10;

    localparam int SAMPLE_W  = 8;
    localparam int TEMP_W    = 7;
    localparam int STEP_W    = 5;
    localparam int TIMEOUT_W = 16;
    localparam int CMD_W     = 3;

    // Signed window sum, wide enough for WINDOW full-scale samples.
    localparam int SUM_W = $clog2(WINDOW * 128) + 1;

    // Largest value the display and the set point can take.
    localparam logic [TEMP_W-1:0] DISPLAY_MAX = 7'd99;

    // Sums at or above this give an average clamped to DISPLAY_MAX.
    localparam int AVG_LIMIT = (99 + 1) * WINDOW;

    // Division by WINDOW as a multiply by a rounded-up reciprocal.
    // The error stays below one quotient step for all sums under AVG_LIMIT.
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_SHIFT-1:0] RECIP_MULT =
        RECIP_SHIFT'((2 ** RECIP_SHIFT + WINDOW - 1) / WINDOW);

    // Event codes.
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POWER  = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_MIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_MAX  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_STEP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 3'd4;

    // Reset values.
    localparam logic [TEMP_W-1:0]    RST_SETPOINT_MIN  = 7'd35;
    localparam logic [TEMP_W-1:0]    RST_SETPOINT_MAX  = 7'd75;
    localparam logic [STEP_W-1:0]    RST_SETPOINT_STEP = 5'd5;
    localparam logic [STEP_W-1:0]    RST_DEADBAND      = 5'd5;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS = 16'd4000;
    localparam logic [TEMP_W-1:0]    RST_SET_POINT     = 7'd60;
    localparam logic [TEMP_W-1:0]    RST_AVERAGE       = 7'd45;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic              display_on;
        logic [TEMP_W-1:0] display_value;
        logic              heat_on;
        logic              cool_on;
        logic              indicator_on;
        logic              in_set_mode;
    } out_item_t;

endpackage

>>> design/thermostat_deadband_controller_top.sv
// Event-driven thermostat with a deadband around the set point.
//
// Input channel (in_valid/in_ready/in_data): one beat carries one event code
// (tick, temperature sample, down, up, power toggle) and a signed sample.
// Output channel (out_valid/out_ready/out_data): exactly one result beat per
// input beat, with display, heat, cool, indicator and set mode flags.
// Configuration (cfg_we/cfg_index/cfg_data): plain writes, taken at once.
//
// A result is written to the output register on the edge that accepts its
// input beat. The block takes one beat per cycle while the output is not
// stalled; the state update and the window average are done combinationally
// between the state registers and the output register.
// While a result waits in the output register and out_ready is low, in_ready
// drops, so the block holds the next beat until the result is taken.
// Reset clears the output valid flag and loads the reset values of the set
// point, average, limits and timers; the sample window starts at zero.
module thermostat_deadband_controller_top
    import tdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [TEMP_W-1:0]    sp_min_reg;
    logic [TEMP_W-1:0]    sp_max_reg;
    logic [STEP_W-1:0]    sp_step_reg;
    logic [STEP_W-1:0]    deadband_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic                 power_on_reg,  power_on_next;
    logic                 set_mode_reg,  set_mode_next;
    logic [TEMP_W-1:0]    set_point_reg, set_point_next;
    logic [TIMEOUT_W-1:0] idle_count_reg, idle_count_next;
    logic                 blink_reg,     blink_next;

    logic                 out_valid_reg;
    out_item_t            out_data_reg;
    out_item_t            result;

    logic                 accept;
    logic                 shift_en;
    logic [TEMP_W-1:0]    average;
    logic [TIMEOUT_W-1:0] idle_inc;
    logic [TEMP_W:0]      sp_up;
    logic [TEMP_W:0]      avg_lo;
    logic [TEMP_W:0]      sp_hi;
    logic                 heat;
    logic                 cool;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign shift_en = accept && (in_data.command == CMD_SAMPLE);

    tdc_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .sample   (in_data.sample),
        .average  (average)
    );

    always_comb
    begin
        power_on_next   = power_on_reg;
        set_mode_next   = set_mode_reg;
        set_point_next  = set_point_reg;
        idle_count_next = idle_count_reg;
        blink_next      = blink_reg;
        idle_inc        = idle_count_reg + 1'b1;
        sp_up           = {1'b0, set_point_reg} + {3'b000, sp_step_reg};

        if (accept)
        begin
            case (in_data.command)
                CMD_TICK:
                begin
                    blink_next = !blink_reg;
                    if (set_mode_reg)
                    begin
                        if (idle_inc >= timeout_reg)
                        begin
                            set_mode_next   = 1'b0;
                            idle_count_next = '0;
                        end
                        else
                        begin
                            idle_count_next = idle_inc;
                        end
                    end
                end
                CMD_DOWN, CMD_UP:
                begin
                    if (power_on_reg)
                    begin
                        idle_count_next = '0;
                        // The press that enters set mode leaves the set point alone.
                        if (!set_mode_reg)
                        begin
                            set_mode_next = 1'b1;
                        end
                        else if (in_data.command == CMD_DOWN)
                        begin
                            if (set_point_reg > sp_min_reg)
                            begin
                                if (set_point_reg < {2'b00, sp_step_reg})
                                begin
                                    set_point_next = '0;
                                end
                                else
                                begin
                                    set_point_next = set_point_reg - {2'b00, sp_step_reg};
                                end
                            end
                        end
                        else if (set_point_reg < sp_max_reg)
                        begin
                            if (sp_up > {1'b0, DISPLAY_MAX})
                            begin
                                set_point_next = DISPLAY_MAX;
                            end
                            else
                            begin
                                set_point_next = sp_up[TEMP_W-1:0];
                            end
                        end
                    end
                end
                CMD_POWER:
                begin
                    power_on_next = !power_on_reg;
                end
                default:
                begin
                end
            endcase
        end

        // Band edges compared without going negative.
        avg_lo = {1'b0, average} + {3'b000, deadband_reg};
        sp_hi  = {1'b0, set_point_next} + {3'b000, deadband_reg};
        heat   = avg_lo < {1'b0, set_point_next};
        cool   = !heat && ({1'b0, average} > sp_hi);

        if (power_on_next)
        begin
            result.display_on    = 1'b1;
            result.display_value = set_mode_next ? set_point_next : average;
            result.heat_on       = heat;
            result.cool_on       = cool;
            result.indicator_on  = heat ? blink_next : cool;
            result.in_set_mode   = set_mode_next;
        end
        else
        begin
            result = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_min_reg   <= RST_SETPOINT_MIN;
            sp_max_reg   <= RST_SETPOINT_MAX;
            sp_step_reg  <= RST_SETPOINT_STEP;
            deadband_reg <= RST_DEADBAND;
            timeout_reg  <= RST_TIMEOUT_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SETPOINT_MIN:  sp_min_reg   <= cfg_data[TEMP_W-1:0];
                CFG_SETPOINT_MAX:  sp_max_reg   <= cfg_data[TEMP_W-1:0];
                CFG_SETPOINT_STEP: sp_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_DEADBAND:      deadband_reg <= cfg_data[STEP_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_reg   <= 1'b0;
            set_mode_reg   <= 1'b0;
            set_point_reg  <= RST_SET_POINT;
            idle_count_reg <= '0;
            blink_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            power_on_reg   <= power_on_next;
            set_mode_reg   <= set_mode_next;
            set_point_reg  <= set_point_next;
            idle_count_reg <= idle_count_next;
            blink_reg      <= blink_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every accepted beat leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted beat produced no result");

    // A waiting result is never overwritten by a new beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result stalled");

    // A power toggle flips the reported display state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.command == CMD_POWER) |=>
            (out_data.display_on == !$past(power_on_reg)))
        else $error("power toggle not reflected in result");

    // Heat and cool are never driven together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.heat_on && out_data.cool_on))
        else $error("heat and cool both on");

endmodule

>>> design/tdc_window.sv
module tdc_window
    import tdc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift_en,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic [TEMP_W-1:0]          average
);

    logic signed [SAMPLE_W-1:0] window_reg [WINDOW];
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic [TEMP_W-1:0]          avg_reg;
    logic [TEMP_W-1:0]          avg_next;
    logic [SUM_W-2:0]           magnitude;
    logic [SUM_W-2+RECIP_SHIFT:0] product;

    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(window_reg[0]) + SUM_W'(sample);
        magnitude = sum_next[SUM_W-2:0];
        product   = {{RECIP_SHIFT{1'b0}}, magnitude} * {{(SUM_W-1){1'b0}}, RECIP_MULT};
        // A negative sum clamps the average to zero.
        if (sum_next[SUM_W-1])
        begin
            avg_next = '0;
        end
        else if (magnitude >= (SUM_W-1)'(AVG_LIMIT))
        begin
            avg_next = DISPLAY_MAX;
        end
        else
        begin
            avg_next = product[RECIP_SHIFT +: TEMP_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
            sum_reg <= '0;
            avg_reg <= RST_AVERAGE;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[WINDOW-1] <= sample;
            sum_reg <= sum_next;
            avg_reg <= avg_next;
        end
    end

    // The average as it stands after the current beat.
    assign average = shift_en ? avg_next : avg_reg;

endmodule
